/* rtl/mcuf_pkg.sv */
// Package for the motor command UART framer: codes, constants and helpers.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mcuf_pkg;

   typedef enum logic [1:0] {
      ACT_DUTY    = 2'd0,
      ACT_SPEED   = 2'd1,
      ACT_VALUES  = 2'd2,
      ACT_FORWARD = 2'd3
   } action_type;

   localparam logic [7:0]  FRAME_START = 8'h02;
   localparam logic [7:0]  FRAME_END   = 8'h03;
   localparam logic [7:0]  CMD_SPEED   = 8'd5;
   localparam logic [7:0]  CMD_VALUES  = 8'd4;
   localparam logic [7:0]  CMD_FORWARD = 8'd33;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [31:0] ONE_BITS    = 32'h3F80_0000;
   localparam logic [31:0] INF_BITS    = 32'h7F80_0000;
   localparam int          MAX_BYTES   = 12;
   localparam int          IDX_W       = $clog2(MAX_BYTES);
   localparam int          QDEPTH      = 2;

   typedef logic [IDX_W-1:0] idx_type;

   // One framed packet held in flat form, bytes in send order.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      idx_type                   last_idx;
   } frame_type;

   // One byte of CRC16/XMODEM, MSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* rtl/mcuf_if.sv */
// Valid/ready channel interfaces for the framer.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface mcuf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] value;
   logic [7:0]  target_id;
   modport source (output valid, action, value, target_id, input ready);
   modport sink (input valid, action, value, target_id, output ready);
endinterface

interface mcuf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;
   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink (input valid, frame_byte, last_byte, output ready);
endinterface
`default_nettype wire

/* rtl/motor_command_uart_framer_core.sv */
// Top level of the motor command UART framer: front end, queue, byte sender.
// Depends on mcuf_pkg, mcuf_if, mcuf_front, mcuf_queue, mcuf_back.
//
//   channel | dir | payload                        | handshake
//   req     | in  | action[2] value[32] target_id[8] | req_valid/req_ready
//   rsp     | out | frame_byte[8] last_byte[1]      | rsp_valid/rsp_ready
//
// One byte leaves per cycle while rsp_ready is high; a frame has 6, 10 or 12 bytes.
// An accepted command passes the payload and frame registers on its way to the queue.
// Reset is synchronous and clears all valid flags, pointers and the byte index.
// Either side may stall; the two-frame queue lets commands come in while bytes go out.
`timescale 1ns / 1ps
`default_nettype none
module motor_command_uart_framer_core (
   input wire logic   clock,
   input wire logic   reset,
   mcuf_req_if.sink   req,
   mcuf_rsp_if.source rsp
);
   import mcuf_pkg::*;

   logic      f_valid, f_ready, q_valid, q_ready;
   frame_type f_frame, q_frame;

   mcuf_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .in_action(req.action), .in_value(req.value), .in_target(req.target_id),
      .out_valid(f_valid), .out_ready(f_ready), .out_frame(f_frame)
   );

   mcuf_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_frame(f_frame),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_frame(q_frame)
   );

   mcuf_back u_back (
      .clock, .reset,
      .fr_valid(q_valid), .fr_ready(q_ready), .fr_frame(q_frame),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_byte(rsp.frame_byte), .out_last(rsp.last_byte)
   );
endmodule
`default_nettype wire

/* rtl/mcuf_front.sv */
// Front end: accepts a command word, builds the payload and the CRC.
// Depends on mcuf_pkg. The CRC runs over a registered payload in a second stage.
`timescale 1ns / 1ps
`default_nettype none
module mcuf_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [1:0]         in_action,
   input  wire logic [31:0]        in_value,
   input  wire logic [7:0]         in_target,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output mcuf_pkg::frame_type     out_frame
);
   import mcuf_pkg::*;

   logic            s1_valid_ff, s1_valid_in;
   logic [6:0][7:0] pay_ff, pay_in;
   logic [2:0]      plen_ff, plen_in;
   logic            s2_valid_ff, s2_valid_in;
   frame_type       frame_ff, frame_in;
   logic            s1_go, s2_go;
   logic [31:0]     duty;
   logic [15:0]     crc;

   // Stage flow: each stage moves when the next one is free or draining.
   assign s2_go    = !s2_valid_ff || out_ready;
   assign s1_go    = !s1_valid_ff || s2_go;
   assign in_ready = s1_go;

   // Duty clamp on the bit pattern; NaN passes.
   always_comb begin
      duty = in_value;
      if (in_value[30:0] <= INF_BITS[30:0] && in_value[30:0] > ONE_BITS[30:0]) begin
         duty = {in_value[31], ONE_BITS[30:0]};
      end
   end

   // Payload build by command.
   always_comb begin
      pay_in  = '0;
      plen_in = 3'd5;
      unique case (action_type'(in_action))
         ACT_DUTY: begin
            pay_in[0] = CMD_SPEED;
            pay_in[1] = duty[7:0];
            pay_in[2] = duty[15:8];
            pay_in[3] = duty[23:16];
            pay_in[4] = duty[31:24];
         end
         ACT_SPEED: begin
            pay_in[0] = CMD_SPEED;
            pay_in[1] = in_value[31:24];
            pay_in[2] = in_value[23:16];
            pay_in[3] = in_value[15:8];
            pay_in[4] = in_value[7:0];
         end
         ACT_VALUES: begin
            pay_in[0] = CMD_VALUES;
            plen_in   = 3'd1;
         end
         ACT_FORWARD: begin
            pay_in[0] = CMD_FORWARD;
            pay_in[1] = in_target;
            pay_in[2] = CMD_SPEED;
            pay_in[3] = in_value[31:24];
            pay_in[4] = in_value[23:16];
            pay_in[5] = in_value[15:8];
            pay_in[6] = in_value[7:0];
            plen_in   = 3'd7;
         end
         default: ;
      endcase
   end

   assign s1_valid_in = s1_go ? in_valid : s1_valid_ff;

   // CRC over the registered payload and frame assembly.
   always_comb begin
      crc = '0;
      for (int i = 0; i < 7; i++) begin
         if (3'(i) < plen_ff) crc = crc_byte(crc, pay_ff[i]);
      end
      frame_in          = '0;
      frame_in.bytes[0] = FRAME_START;
      frame_in.bytes[1] = {5'd0, plen_ff};
      for (int i = 0; i < 7; i++) begin
         if (3'(i) < plen_ff) frame_in.bytes[i + 2] = pay_ff[i];
      end
      frame_in.bytes[IDX_W'(plen_ff) + 4'd2] = crc[15:8];
      frame_in.bytes[IDX_W'(plen_ff) + 4'd3] = crc[7:0];
      frame_in.bytes[IDX_W'(plen_ff) + 4'd4] = FRAME_END;
      frame_in.last_idx = IDX_W'(plen_ff) + 4'd4;
   end

   assign s2_valid_in = s2_go ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload registers load only on a move.
   always_ff @(posedge clock) begin
      if (s1_go) begin
         pay_ff  <= pay_in;
         plen_ff <= plen_in;
      end
      if (s2_go) frame_ff <= frame_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_frame = frame_ff;

   a_len: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (plen_ff == 3'd1 || plen_ff == 3'd5 || plen_ff == 3'd7))
      else $error("bad payload length");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_ready |=> s2_valid_ff && $stable(frame_ff))
      else $error("frame lost under stall");
   a_end: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> frame_ff.bytes[frame_ff.last_idx] == FRAME_END)
      else $error("frame end marker misplaced");
endmodule
`default_nettype wire

/* rtl/mcuf_queue.sv */
// Short frame queue between the front end and the byte sender.
// Depends on mcuf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcuf_queue (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           wr_valid,
   output logic                wr_ready,
   input  mcuf_pkg::frame_type wr_frame,
   output logic                rd_valid,
   input  wire logic           rd_ready,
   output mcuf_pkg::frame_type rd_frame
);
   import mcuf_pkg::*;

   frame_type mem_ff [QDEPTH];
   logic      wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      wr, rd;

   assign wr_ready = cnt_ff != 2'(QDEPTH);
   assign rd_valid = cnt_ff != 2'd0;
   assign wr       = wr_valid && wr_ready;
   assign rd       = rd_valid && rd_ready;
   assign rd_frame = mem_ff[rp_ff];

   // Pointer and count update.
   always_comb begin
      wp_in  = wr ? !wp_ff : wp_ff;
      rp_in  = rd ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(wr) - 2'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_frame;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QDEPTH)) else $error("queue count overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> (wp_ff != rp_ff)) else $error("queue pointers out of step");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'(QDEPTH)) |-> (wp_ff == rp_ff)) else $error("full queue pointers");
endmodule
`default_nettype wire

/* rtl/mcuf_back.sv */
// Back end: sends a queued frame one byte per cycle through an output register
// while out_ready allows. Depends on mcuf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcuf_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           fr_valid,
   output logic                fr_ready,
   input  mcuf_pkg::frame_type fr_frame,
   output logic                out_valid,
   input  wire logic           out_ready,
   output logic [7:0]          out_byte,
   output logic                out_last
);
   import mcuf_pkg::*;

   idx_type    idx_ff, idx_in;
   logic       v_ff, v_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       load, is_last;

   // Output register refills when empty or taken.
   assign load     = fr_valid && (!v_ff || out_ready);
   assign is_last  = idx_ff == fr_frame.last_idx;
   assign fr_ready = load && is_last;

   always_comb begin
      idx_in  = idx_ff;
      v_in    = v_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      if (!v_ff || out_ready) v_in = fr_valid;
      if (load) begin
         byte_in = fr_frame.bytes[idx_ff];
         last_in = is_last;
         idx_in  = is_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         v_ff   <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         v_ff   <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign out_valid = v_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

   a_idx: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(MAX_BYTES - 1)) else $error("byte index out of range");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      fr_ready |=> idx_ff == '0) else $error("index not cleared after frame");
   a_lastend: assert property (@(posedge clock) disable iff (reset)
      v_ff && last_ff |-> byte_ff == FRAME_END) else $error("last flag off end marker");
endmodule
`default_nettype wire

/* sim/mcuf_checker.sv */
// Checker for the motor command UART framer: watches both channels, predicts each frame
// and compares every output byte. Depends on mcuf_pkg and mcuf_if.
`timescale 1ns / 1ps
`default_nettype none
module mcuf_checker (
   input wire logic clock,
   input wire logic reset,
   mcuf_req_if      req,
   mcuf_rsp_if      rsp,
   output int       fail_count,
   output int       pending_bytes
);
   import mcuf_pkg::*;

   typedef struct {
      logic [7:0] frame_byte;
      logic       last_byte;
   } frame_word;

   frame_word byte_queue[$];

   // CRC16/XMODEM over one byte, MSB first.
   function automatic logic [15:0] xmodem_step(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ 16'h1021;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Clamp a duty bit pattern to +/-1.0; NaN passes untouched.
   function automatic logic [31:0] limit_duty(logic [31:0] bits);
      if (bits[30:0] > 31'h7F80_0000) begin
         return bits;
      end
      if (bits[30:0] > 31'h3F80_0000) begin
         return {bits[31], 31'h3F80_0000};
      end
      return bits;
   endfunction

   // Build the frame for one command and append its bytes.
   task automatic queue_frame(action_type act, logic [31:0] value, logic [7:0] target);
      logic [7:0]  payload[$];
      logic [7:0]  frame[$];
      logic [15:0] crc;
      logic [31:0] duty;
      crc = '0;
      duty = limit_duty(value);
      case (act)
         ACT_DUTY: begin
            payload = '{CMD_SPEED, duty[7:0], duty[15:8], duty[23:16], duty[31:24]};
         end
         ACT_SPEED: begin
            payload = '{CMD_SPEED, value[31:24], value[23:16], value[15:8], value[7:0]};
         end
         ACT_VALUES: begin
            payload = '{CMD_VALUES};
         end
         default: begin
            payload = '{CMD_FORWARD, target, CMD_SPEED,
                        value[31:24], value[23:16], value[15:8], value[7:0]};
         end
      endcase
      foreach (payload[i]) crc = xmodem_step(crc, payload[i]);
      frame = '{FRAME_START, 8'(payload.size())};
      frame = {frame, payload};
      frame = {frame, crc[15:8], crc[7:0], FRAME_END};
      foreach (frame[i]) byte_queue.push_back('{frame[i], i == frame.size() - 1});
   endtask

   assign pending_bytes = byte_queue.size();

   // Predict on each accepted command, compare on each accepted byte.
   always @(posedge clock) begin
      frame_word want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req.valid && req.ready) begin
            queue_frame(action_type'(req.action), req.value, req.target_id);
         end
         if (rsp.valid && rsp.ready) begin
            if (byte_queue.size() == 0) begin
               $display("%0t: unexpected word, actual byte %h last %b",
                        $time, rsp.frame_byte, rsp.last_byte);
               fail_count <= fail_count + 1;
            end else begin
               want = byte_queue.pop_front();
               if (want.frame_byte !== rsp.frame_byte || want.last_byte !== rsp.last_byte) begin
                  $display("%0t: mismatch, expected byte %h last %b, actual byte %h last %b",
                           $time, want.frame_byte, want.last_byte,
                           rsp.frame_byte, rsp.last_byte);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

/* sim/motor_command_uart_framer_core_test.sv */
// Testbench top for the motor command UART framer: stimulus, idling, watchdog and verdict.
// Depends on mcuf_pkg, mcuf_if, mcuf_checker and the framer RTL.
`timescale 1ns / 1ps
`default_nettype none
module motor_command_uart_framer_core_test;
   import mcuf_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_bytes;
   int   send_idle_pct = 36;
   int   recv_idle_pct = 56;
   bit   hold_off = 1'b0;
   int   quiet_cycles = 0;

   mcuf_req_if req ();
   mcuf_rsp_if rsp ();

   motor_command_uart_framer_core i_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));
   mcuf_checker i_checker (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                           .fail_count(fail_count), .pending_bytes(pending_bytes));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.action = '0;
      req.value = '0;
      req.target_id = '0;
      rsp.ready = 1'b0;
   end

   // Receiver readiness, with a long hold-off when asked.
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles with no accepted word.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Offer one command after random gaps and wait for its accept. Valid stays high
   // after the accept so that back-to-back commands need only one drive per edge.
   task automatic send_cmd(action_type act, logic [31:0] value, logic [7:0] target);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.action <= act;
      req.value <= value;
      req.target_id <= target;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic send_random();
      logic [31:0] v;
      int          pick;
      v = $urandom();
      pick = $urandom_range(9);
      // Bias duty values toward the clamp edges and special patterns.
      if (pick == 0) v = {v[31], 31'h3F80_0000};
      else if (pick == 1) v = {v[31], 31'h3F80_0001};
      else if (pick == 2) v = {v[31], 8'hFF, v[22:0]};
      else if (pick == 3) v = {v[31], 4'h3, v[26:0]};
      send_cmd(action_type'($urandom_range(3)), v, 8'($urandom()));
   endtask

   // Stop offering and wait until every expected byte has come out.
   task automatic drain();
      req.valid <= 1'b0;
      while (pending_bytes != 0) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed commands: every action, clamp edges, NaN, infinities, zeros.
      send_cmd(ACT_VALUES, 32'hFFFF_FFFF, 8'hFF);
      send_cmd(ACT_SPEED, 32'h0000_0000, 8'h00);
      send_cmd(ACT_SPEED, 32'hFFFF_FFFF, 8'hFF);
      send_cmd(ACT_SPEED, 32'h8000_0000, 8'h5A);
      send_cmd(ACT_FORWARD, 32'h7FFF_FFFF, 8'h00);
      send_cmd(ACT_FORWARD, 32'h8000_0000, 8'hFF);
      send_cmd(ACT_FORWARD, 32'hA5A5_5A5A, 8'h81);
      send_cmd(ACT_DUTY, 32'h3F80_0000, 8'h00);
      send_cmd(ACT_DUTY, 32'hBF80_0000, 8'h00);
      send_cmd(ACT_DUTY, 32'h3F80_0001, 8'h00);
      send_cmd(ACT_DUTY, 32'hBF80_0001, 8'h00);
      send_cmd(ACT_DUTY, 32'h7F80_0000, 8'h00);
      send_cmd(ACT_DUTY, 32'hFF80_0000, 8'h00);
      send_cmd(ACT_DUTY, 32'h7FC0_0000, 8'h00);
      send_cmd(ACT_DUTY, 32'hFF80_0001, 8'h00);
      send_cmd(ACT_DUTY, 32'h0000_0000, 8'h00);
      send_cmd(ACT_DUTY, 32'h8000_0000, 8'h00);
      send_cmd(ACT_DUTY, 32'h0000_0001, 8'h00);
      send_cmd(ACT_DUTY, 32'h3F00_0000, 8'hFF);
      send_cmd(ACT_DUTY, 32'hC2C8_0000, 8'hFF);

      // Sender pauses until the whole backlog is out.
      drain();

      // Receiver holds off while commands keep coming, filling the queue.
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (6) send_random();
      join

      repeat (100) send_random();
      drain();
      send_idle_pct = 56;
      recv_idle_pct = 36;
      repeat (100) send_random();
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (100) send_random();

      drain();
      repeat (30) @(posedge clock);
      if (fail_count == 0 && pending_bytes == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
rtl/mcuf_pkg.sv
rtl/mcuf_if.sv
rtl/mcuf_front.sv
rtl/mcuf_queue.sv
rtl/mcuf_back.sv
rtl/motor_command_uart_framer_core.sv
sim/mcuf_checker.sv
sim/motor_command_uart_framer_core_test.sv
